### src/two_pad_eta_position_correction_top_macros.svh
// assertion macros for the two-pad eta position correction block
// used by two_pad_eta_position_correction_top; expects clk and rst_n in scope
`ifndef TWO_PAD_ETA_POSITION_CORRECTION_TOP_MACROS_SVH
`define TWO_PAD_ETA_POSITION_CORRECTION_TOP_MACROS_SVH

// property that must hold at every edge out of reset
`define TPEPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent in this cycle implies consequent in the next
`define TPEPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/tpepc_pkg.sv
// shared types, widths, codes and saturation helper for the eta correction block
// no dependencies; used by tpepc_norm, tpepc_poly and the top level
`default_nettype none

package tpepc_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int POLY_TERMS_DEF = 6;
    localparam int N_COEF         = 6;

    localparam int DATA_W    = 32;
    localparam int AMP_W     = 16;
    localparam int SUM_W     = AMP_W + 1;
    localparam int ETA_W     = FRAC_BITS + 1;
    localparam int UNIT_W    = ETA_W + 1;
    localparam int MAG_W     = DATA_W - 1;
    localparam int SQ_W      = 2 * MAG_W + 1;
    localparam int ROOT_W    = DATA_W;
    localparam int SAT_W     = DATA_W + 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_0 = CFG_IDX_W'(1);

    localparam logic [1:0] ST_CORRECTED  = 2'd0;
    localparam logic [1:0] ST_PASSED     = 2'd1;
    localparam logic [1:0] ST_ZERO_SUM   = 2'd2;
    localparam logic [1:0] ST_COINCIDENT = 2'd3;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef data_t coef_arr_t [N_COEF];

    typedef struct packed {
        data_t              pos_x;
        data_t              pos_y;
        logic               two_pad;
        data_t              pad0_x;
        data_t              pad0_y;
        data_t              pad1_x;
        data_t              pad1_y;
        logic [AMP_W-1:0]   amp0;
        logic [AMP_W-1:0]   amp1;
    } item_t;

    typedef struct packed {
        data_t                    pos_x;
        data_t                    pos_y;
        logic [1:0]               status;
        logic [ETA_W-1:0]         eta;
        logic signed [UNIT_W-1:0] ux;
        logic signed [UNIT_W-1:0] uy;
    } norm_t;

    typedef struct packed {
        data_t      new_x;
        data_t      new_y;
        data_t      shift;
        logic [1:0] status;
    } res_t;

    function automatic data_t sat_data(input logic signed [SAT_W-1:0] v);
        logic [SAT_W-DATA_W:0] top_bits;
        top_bits = v[SAT_W-1:DATA_W-1];
        if (top_bits == '0 || top_bits == '1)
        begin
            return v[DATA_W-1:0];
        end
        else if (v[SAT_W-1])
        begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

### src/tpepc_norm.sv
// front end: status, pad axis, square root of its length, unit vector and eta
// one bit of root or quotient per stage; depends on tpepc_pkg
`default_nettype none

module tpepc_norm
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_v,
    input  tpepc_pkg::item_t      in_item,
    output logic                  out_v,
    output tpepc_pkg::norm_t      out_item
);

    localparam int DATA_W = tpepc_pkg::DATA_W;
    localparam int AMP_W  = tpepc_pkg::AMP_W;
    localparam int SUM_W  = tpepc_pkg::SUM_W;
    localparam int ETA_W  = tpepc_pkg::ETA_W;
    localparam int UNIT_W = tpepc_pkg::UNIT_W;
    localparam int MAG_W  = tpepc_pkg::MAG_W;
    localparam int ROOT_W = tpepc_pkg::ROOT_W;
    localparam int V_W    = 2 * ROOT_W;
    localparam int SR_W   = ROOT_W + 2;
    localparam int NST    = 2 + (ROOT_W + 1) + (ETA_W + 1);

    typedef struct packed {
        tpepc_pkg::data_t   pos_x;
        tpepc_pkg::data_t   pos_y;
        logic [1:0]         status;
        logic               sy;
        logic [MAG_W-1:0]   rx;
        logic [MAG_W-1:0]   ry;
        logic [AMP_W-1:0]   small_amp;
        logic [SUM_W-1:0]   sum;
    } s1_t;

    typedef struct packed {
        s1_t                b;
        logic [2*MAG_W-1:0] sqx;
        logic [2*MAG_W-1:0] sqy;
    } s2_t;

    typedef struct packed {
        s1_t                b;
        logic [V_W-1:0]     v;
        logic [SR_W-1:0]    r;
        logic [ROOT_W-1:0]  q;
        logic [SUM_W-1:0]   erem;
        logic [ETA_W-1:0]   eq;
    } sq_t;

    typedef struct packed {
        tpepc_pkg::data_t   pos_x;
        tpepc_pkg::data_t   pos_y;
        logic [1:0]         status;
        logic               sy;
        logic [MAG_W-1:0]   rx;
        logic [MAG_W-1:0]   ry;
        logic [ROOT_W-1:0]  len;
        logic [ROOT_W-1:0]  xrem;
        logic [ROOT_W-1:0]  yrem;
        logic [ETA_W-1:0]   xq;
        logic [ETA_W-1:0]   yq;
        logic [ETA_W-1:0]   eta;
    } dv_t;

    logic [NST-1:0] vld_reg;
    s1_t            s1_reg, s1_next;
    s2_t            s2_reg, s2_next;
    sq_t            sq_reg [0:ROOT_W];
    sq_t            sq0_next;
    dv_t            dv_reg [0:ETA_W];
    dv_t            dv0_next;

    logic signed [DATA_W:0] ax, ay, axf, ayf;
    logic [DATA_W-1:0]      mx, my;
    logic                   shift_dn;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_v};
        end
    end

    // axis, flip, scale-down and status
    always_comb
    begin
        ax  = $signed({in_item.pad0_x[DATA_W-1], in_item.pad0_x})
            - $signed({in_item.pad1_x[DATA_W-1], in_item.pad1_x});
        ay  = $signed({in_item.pad0_y[DATA_W-1], in_item.pad0_y})
            - $signed({in_item.pad1_y[DATA_W-1], in_item.pad1_y});
        axf = ax[DATA_W] ? -ax : ax;
        ayf = ax[DATA_W] ? -ay : ay;
        mx  = axf[DATA_W-1:0];
        my  = ayf[DATA_W] ? DATA_W'(-ayf) : ayf[DATA_W-1:0];
        shift_dn = mx[DATA_W-1] | my[DATA_W-1];

        s1_next.pos_x = in_item.pos_x;
        s1_next.pos_y = in_item.pos_y;
        s1_next.sy    = ayf[DATA_W];
        s1_next.rx    = shift_dn ? mx[DATA_W-1:1] : mx[DATA_W-2:0];
        s1_next.ry    = shift_dn ? my[DATA_W-1:1] : my[DATA_W-2:0];
        s1_next.small_amp = ($signed(in_item.pad1_x) < $signed(in_item.pad0_x))
                          ? in_item.amp1 : in_item.amp0;
        s1_next.sum   = {1'b0, in_item.amp0} + {1'b0, in_item.amp1};

        if (!in_item.two_pad)
        begin
            s1_next.status = tpepc_pkg::ST_PASSED;
        end
        else if (s1_next.sum == '0)
        begin
            s1_next.status = tpepc_pkg::ST_ZERO_SUM;
        end
        else if (in_item.pad0_x == in_item.pad1_x && in_item.pad0_y == in_item.pad1_y)
        begin
            s1_next.status = tpepc_pkg::ST_COINCIDENT;
        end
        else
        begin
            s1_next.status = tpepc_pkg::ST_CORRECTED;
        end
    end

    always_comb
    begin
        s2_next.b   = s1_reg;
        s2_next.sqx = s1_reg.rx * s1_reg.rx;
        s2_next.sqy = s1_reg.ry * s1_reg.ry;
    end

    always_comb
    begin
        sq0_next.b    = s2_reg.b;
        sq0_next.v    = V_W'({1'b0, s2_reg.sqx} + {1'b0, s2_reg.sqy});
        sq0_next.r    = '0;
        sq0_next.q    = '0;
        sq0_next.erem = SUM_W'(s2_reg.b.small_amp >> 1);
        sq0_next.eq   = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg    <= s1_next;
            s2_reg    <= s2_next;
            sq_reg[0] <= sq0_next;
            dv_reg[0] <= dv0_next;
        end
    end

    // square root, two radicand bits in and one result bit out per stage; eta division rides along
    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_sqrt
        logic [SR_W+1:0] r2, t;
        logic [SUM_W:0]  e2;
        logic            ebit;
        sq_t             nxt;

        always_comb
        begin
            nxt    = sq_reg[j];
            r2     = {sq_reg[j].r, sq_reg[j].v[V_W-1 -: 2]};
            t      = {2'b00, sq_reg[j].q, 2'b01};
            nxt.v  = sq_reg[j].v << 2;
            if (r2 >= t)
            begin
                nxt.r = SR_W'(r2 - t);
                nxt.q = {sq_reg[j].q[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                nxt.r = SR_W'(r2);
                nxt.q = {sq_reg[j].q[ROOT_W-2:0], 1'b0};
            end

            ebit = (j == 0) ? sq_reg[j].b.small_amp[0] : 1'b0;
            e2   = {sq_reg[j].erem, ebit};
            if (j < ETA_W)
            begin
                if (e2 >= {1'b0, sq_reg[j].b.sum})
                begin
                    nxt.erem = SUM_W'(e2 - {1'b0, sq_reg[j].b.sum});
                    nxt.eq   = {sq_reg[j].eq[ETA_W-2:0], 1'b1};
                end
                else
                begin
                    nxt.erem = SUM_W'(e2);
                    nxt.eq   = {sq_reg[j].eq[ETA_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[j+1] <= nxt;
            end
        end
    end

    always_comb
    begin
        dv0_next.pos_x  = sq_reg[ROOT_W].b.pos_x;
        dv0_next.pos_y  = sq_reg[ROOT_W].b.pos_y;
        dv0_next.status = sq_reg[ROOT_W].b.status;
        dv0_next.sy     = sq_reg[ROOT_W].b.sy;
        dv0_next.rx     = sq_reg[ROOT_W].b.rx;
        dv0_next.ry     = sq_reg[ROOT_W].b.ry;
        dv0_next.len    = (sq_reg[ROOT_W].q == '0) ? ROOT_W'(1) : sq_reg[ROOT_W].q;
        dv0_next.xrem   = ROOT_W'(sq_reg[ROOT_W].b.rx >> 1);
        dv0_next.yrem   = ROOT_W'(sq_reg[ROOT_W].b.ry >> 1);
        dv0_next.xq     = '0;
        dv0_next.yq     = '0;
        dv0_next.eta    = sq_reg[ROOT_W].eq;
    end

    // unit vector components, one quotient bit per stage
    for (genvar j = 0; j < ETA_W; j++)
    begin : g_div
        logic [ROOT_W:0] x2, y2;
        logic            xbit, ybit;
        dv_t             nxt;

        always_comb
        begin
            nxt  = dv_reg[j];
            xbit = (j == 0) ? dv_reg[j].rx[0] : 1'b0;
            ybit = (j == 0) ? dv_reg[j].ry[0] : 1'b0;
            x2   = {dv_reg[j].xrem, xbit};
            y2   = {dv_reg[j].yrem, ybit};
            if (x2 >= {1'b0, dv_reg[j].len})
            begin
                nxt.xrem = ROOT_W'(x2 - {1'b0, dv_reg[j].len});
                nxt.xq   = {dv_reg[j].xq[ETA_W-2:0], 1'b1};
            end
            else
            begin
                nxt.xrem = ROOT_W'(x2);
                nxt.xq   = {dv_reg[j].xq[ETA_W-2:0], 1'b0};
            end
            if (y2 >= {1'b0, dv_reg[j].len})
            begin
                nxt.yrem = ROOT_W'(y2 - {1'b0, dv_reg[j].len});
                nxt.yq   = {dv_reg[j].yq[ETA_W-2:0], 1'b1};
            end
            else
            begin
                nxt.yrem = ROOT_W'(y2);
                nxt.yq   = {dv_reg[j].yq[ETA_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[j+1] <= nxt;
            end
        end
    end

    logic signed [UNIT_W-1:0] uy_mag;

    always_comb
    begin
        uy_mag          = $signed({1'b0, dv_reg[ETA_W].yq});
        out_item.pos_x  = dv_reg[ETA_W].pos_x;
        out_item.pos_y  = dv_reg[ETA_W].pos_y;
        out_item.status = dv_reg[ETA_W].status;
        out_item.eta    = dv_reg[ETA_W].eta;
        out_item.ux     = $signed({1'b0, dv_reg[ETA_W].xq});
        out_item.uy     = dv_reg[ETA_W].sy ? -uy_mag : uy_mag;
    end

    assign out_v = vld_reg[NST-1];

endmodule

`default_nettype wire

### src/tpepc_poly.sv
// back end: horner evaluation of the shift polynomial and the position update
// one multiply stage and one add stage per term; depends on tpepc_pkg
`default_nettype none

module tpepc_poly
#(
    parameter int POLY_TERMS = tpepc_pkg::POLY_TERMS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_v,
    input  tpepc_pkg::norm_t          in_item,
    input  tpepc_pkg::coef_arr_t      coef,
    output logic                      out_v,
    output tpepc_pkg::res_t           out_item
);

    localparam int FB     = tpepc_pkg::FRAC_BITS;
    localparam int DATA_W = tpepc_pkg::DATA_W;
    localparam int ETA_W  = tpepc_pkg::ETA_W;
    localparam int SAT_W  = tpepc_pkg::SAT_W;
    localparam int N_COEF = tpepc_pkg::N_COEF;
    localparam int PM_W   = DATA_W + ETA_W + 1;
    localparam int LAST   = 2 * POLY_TERMS + 1;
    localparam int NST    = LAST + 2;

    typedef struct packed {
        tpepc_pkg::norm_t       b;
        tpepc_pkg::data_t       acc;
        logic signed [PM_W-1:0] prod;
        logic signed [PM_W-1:0] prod2;
    } pl_t;

    logic [NST-1:0]   vld_reg;
    pl_t              st_reg [0:LAST];
    pl_t              st0_next;
    tpepc_pkg::res_t  res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_v};
        end
    end

    always_comb
    begin
        st0_next.b     = in_item;
        st0_next.acc   = '0;
        st0_next.prod  = '0;
        st0_next.prod2 = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= st0_next;
            res_reg   <= res_next;
        end
    end

    for (genvar t = 0; t < POLY_TERMS; t++)
    begin : g_term
        localparam int K = POLY_TERMS - 1 - t;
        logic signed [DATA_W:0] sh;
        tpepc_pkg::data_t       c;
        pl_t                    mul_nxt, add_nxt;

        if (K < N_COEF)
        begin : g_coef
            assign c = coef[K];
        end
        else
        begin : g_zero
            assign c = '0;
        end

        always_comb
        begin
            mul_nxt      = st_reg[2*t];
            mul_nxt.prod = st_reg[2*t].acc * $signed({1'b0, st_reg[2*t].b.eta});
        end

        always_comb
        begin
            add_nxt     = st_reg[2*t+1];
            sh          = st_reg[2*t+1].prod[FB +: DATA_W+1];
            add_nxt.acc = tpepc_pkg::sat_data(
                              $signed({{(SAT_W-DATA_W-1){sh[DATA_W]}}, sh})
                            + $signed({{(SAT_W-DATA_W){c[DATA_W-1]}}, c}));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[2*t+1] <= mul_nxt;
                st_reg[2*t+2] <= add_nxt;
            end
        end
    end

    pl_t fm_nxt;

    always_comb
    begin
        fm_nxt       = st_reg[LAST-1];
        fm_nxt.prod  = st_reg[LAST-1].acc * st_reg[LAST-1].b.ux;
        fm_nxt.prod2 = st_reg[LAST-1].acc * st_reg[LAST-1].b.uy;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[LAST] <= fm_nxt;
        end
    end

    logic signed [DATA_W:0] dx, dy;

    // position update, unshifted unless corrected
    always_comb
    begin
        dx = st_reg[LAST].prod[FB +: DATA_W+1];
        dy = st_reg[LAST].prod2[FB +: DATA_W+1];
        res_next.status = st_reg[LAST].b.status;
        if (st_reg[LAST].b.status == tpepc_pkg::ST_CORRECTED)
        begin
            res_next.new_x = tpepc_pkg::sat_data(
                $signed({{(SAT_W-DATA_W){st_reg[LAST].b.pos_x[DATA_W-1]}}, st_reg[LAST].b.pos_x})
              + $signed({{(SAT_W-DATA_W-1){dx[DATA_W]}}, dx}));
            res_next.new_y = tpepc_pkg::sat_data(
                $signed({{(SAT_W-DATA_W){st_reg[LAST].b.pos_y[DATA_W-1]}}, st_reg[LAST].b.pos_y})
              + $signed({{(SAT_W-DATA_W-1){dy[DATA_W]}}, dy}));
            res_next.shift = st_reg[LAST].acc;
        end
        else
        begin
            res_next.new_x = st_reg[LAST].b.pos_x;
            res_next.new_y = st_reg[LAST].b.pos_y;
            res_next.shift = '0;
        end
    end

    assign out_v    = vld_reg[NST-1];
    assign out_item = res_reg;

endmodule

`default_nettype wire

### src/two_pad_eta_position_correction_top.sv
// top level of the two-pad eta position correction block: config registers,
// output register and skid stage; depends on tpepc_pkg, tpepc_norm, tpepc_poly
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_stall   pos_x pos_y two_pad pad0_* pad1_* amp0 amp1
//   out       output     out_valid / out_stall new_x new_y applied_shift status
//   cfg       input      cfg_wr_en             cfg_index cfg_wr_data
//
// one transaction per cycle while in_stall is low; the pipeline is built from the
// bit-per-stage square root and the bit-per-stage divisions
// reset clears valid bits, config registers, output and skid valid
// a stalled output parks one result in the skid stage; in_stall is that stage's valid
// items arriving while correction is disabled are taken and dropped
`default_nettype none
`include "two_pad_eta_position_correction_top_macros.svh"

module two_pad_eta_position_correction_top
#(
    parameter int POLY_TERMS = tpepc_pkg::POLY_TERMS_DEF
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [tpepc_pkg::DATA_W-1:0]   pos_x,
    input  wire logic signed [tpepc_pkg::DATA_W-1:0]   pos_y,
    input  wire logic                                  two_pad,
    input  wire logic signed [tpepc_pkg::DATA_W-1:0]   pad0_x,
    input  wire logic signed [tpepc_pkg::DATA_W-1:0]   pad0_y,
    input  wire logic signed [tpepc_pkg::DATA_W-1:0]   pad1_x,
    input  wire logic signed [tpepc_pkg::DATA_W-1:0]   pad1_y,
    input  wire logic [tpepc_pkg::AMP_W-1:0]           amp0,
    input  wire logic [tpepc_pkg::AMP_W-1:0]           amp1,

    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [tpepc_pkg::DATA_W-1:0]        new_x,
    output logic signed [tpepc_pkg::DATA_W-1:0]        new_y,
    output logic signed [tpepc_pkg::DATA_W-1:0]        applied_shift,
    output logic [1:0]                                 status,

    input  wire logic                                  cfg_wr_en,
    input  wire logic [tpepc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [tpepc_pkg::DATA_W-1:0]          cfg_wr_data
);

    localparam int N_COEF    = tpepc_pkg::N_COEF;
    localparam int CFG_IDX_W = tpepc_pkg::CFG_IDX_W;

    logic                  enabled_reg;
    tpepc_pkg::coef_arr_t  coef_reg;
    tpepc_pkg::item_t      in_item;
    tpepc_pkg::norm_t      norm_item;
    tpepc_pkg::res_t       pipe_item;
    tpepc_pkg::res_t       out_reg, skid_reg;
    logic                  out_valid_reg, skid_v_reg;
    logic                  norm_v, pipe_v, adv, out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            for (int k = 0; k < N_COEF; k++)
            begin
                coef_reg[k] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == tpepc_pkg::CFG_ENABLE)
            begin
                enabled_reg <= cfg_wr_data[0];
            end
            for (int k = 0; k < N_COEF; k++)
            begin
                if (cfg_index == CFG_IDX_W'(tpepc_pkg::CFG_COEF_0 + k))
                begin
                    coef_reg[k] <= cfg_wr_data;
                end
            end
        end
    end

    always_comb
    begin
        in_item.pos_x   = pos_x;
        in_item.pos_y   = pos_y;
        in_item.two_pad = two_pad;
        in_item.pad0_x  = pad0_x;
        in_item.pad0_y  = pad0_y;
        in_item.pad1_x  = pad1_x;
        in_item.pad1_y  = pad1_y;
        in_item.amp0    = amp0;
        in_item.amp1    = amp1;
    end

    assign adv      = !skid_v_reg;
    assign in_stall = skid_v_reg;
    assign out_free = !out_valid_reg || !out_stall;

    tpepc_norm u_norm
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_v     (in_valid && enabled_reg),
        .in_item  (in_item),
        .out_v    (norm_v),
        .out_item (norm_item)
    );

    tpepc_poly #(.POLY_TERMS(POLY_TERMS)) u_poly
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_v     (norm_v),
        .in_item  (norm_item),
        .coef     (coef_reg),
        .out_v    (pipe_v),
        .out_item (pipe_item)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_v_reg    <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (out_free)
            begin
                out_valid_reg <= 1'b1;
                skid_v_reg    <= 1'b0;
            end
        end
        else if (pipe_v)
        begin
            if (out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_v_reg <= 1'b1;
            end
        end
        else if (out_free)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (out_free)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (pipe_v)
        begin
            if (out_free)
            begin
                out_reg <= pipe_item;
            end
            else
            begin
                skid_reg <= pipe_item;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign new_x         = out_reg.new_x;
    assign new_y         = out_reg.new_y;
    assign applied_shift = out_reg.shift;
    assign status        = out_reg.status;

    `TPEPC_ASSERT(a_skid_implies_out, skid_v_reg |-> out_valid_reg, "skid holds data while output empty")
    `TPEPC_ASSERT(a_skid_fill, $rose(skid_v_reg) |-> $past(out_valid_reg && out_stall), "skid filled without output stall")
    `TPEPC_ASSERT_NEXT(a_skid_drain, skid_v_reg && !out_stall, !skid_v_reg, "skid not drained")
    `TPEPC_ASSERT(a_shift_zero, (out_valid_reg && out_reg.status != tpepc_pkg::ST_CORRECTED) |-> (out_reg.shift == '0), "shift nonzero on uncorrected result")

endmodule

`default_nettype wire

### sim/two_pad_eta_position_correction_checker.sv
// cluster correction checker: watches the input, output and config ports of the block,
// predicts each corrected position and compares it field by field; uses tpepc_pkg
module two_pad_eta_position_correction_checker
    import tpepc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  data_t                pos_x,
    input  data_t                pos_y,
    input  logic                 two_pad,
    input  data_t                pad0_x,
    input  data_t                pad0_y,
    input  data_t                pad1_x,
    input  data_t                pad1_y,
    input  logic [AMP_W-1:0]     amp0,
    input  logic [AMP_W-1:0]     amp1,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  data_t                new_x,
    input  data_t                new_y,
    input  data_t                applied_shift,
    input  logic [1:0]           status,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_wr_data,
    output int                   fail_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TERMS = POLY_TERMS_DEF;

    logic  corr_on;
    data_t coef_q [N_COEF];
    res_t  corrected_q [$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint floor_root(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
        begin
            bitv = bitv >> 2;
        end
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(root);
    endfunction

    function automatic res_t correct_cluster(input item_t c);
        res_t   r;
        longint ax, ay, rx, ry, len, ux, uy, eta, small_amp, acc;
        r.new_x  = c.pos_x;
        r.new_y  = c.pos_y;
        r.shift  = '0;
        if (!c.two_pad)
        begin
            r.status = ST_PASSED;
        end
        else if (c.amp0 == 0 && c.amp1 == 0)
        begin
            r.status = ST_ZERO_SUM;
        end
        else if (c.pad0_x == c.pad1_x && c.pad0_y == c.pad1_y)
        begin
            r.status = ST_COINCIDENT;
        end
        else
        begin
            ax = longint'(c.pad0_x) - longint'(c.pad1_x);
            ay = longint'(c.pad0_y) - longint'(c.pad1_y);
            if (ax < 0)
            begin
                ax = -ax;
                ay = -ay;
            end
            rx = (ax < 0) ? -ax : ax;
            ry = (ay < 0) ? -ay : ay;
            while (rx >= 64'sh80000000 || ry >= 64'sh80000000)
            begin
                rx = rx >>> 1;
                ry = ry >>> 1;
            end
            len = floor_root(rx * rx + ry * ry);
            if (len == 0)
            begin
                len = 1;
            end
            ux = (rx <<< FRAC_BITS) / len;
            uy = (ry <<< FRAC_BITS) / len;
            if (ax < 0)
            begin
                ux = -ux;
            end
            if (ay < 0)
            begin
                uy = -uy;
            end
            small_amp = (c.pad1_x < c.pad0_x) ? longint'(c.amp1) : longint'(c.amp0);
            eta = (small_amp <<< FRAC_BITS) / (longint'(c.amp0) + longint'(c.amp1));
            acc = 0;
            for (int k = TERMS - 1; k >= 0; k--)
            begin
                acc = clamp32(((acc * eta) >>> FRAC_BITS)
                              + ((k < N_COEF) ? longint'(coef_q[k]) : 0));
            end
            r.shift  = data_t'(acc);
            r.new_x  = data_t'(clamp32(longint'(c.pos_x) + ((acc * ux) >>> FRAC_BITS)));
            r.new_y  = data_t'(clamp32(longint'(c.pos_y) + ((acc * uy) >>> FRAC_BITS)));
            r.status = ST_CORRECTED;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        item_t c;
        res_t  e;
        if (!rst_n)
        begin
            corr_on <= 1'b0;
            for (int k = 0; k < N_COEF; k++)
            begin
                coef_q[k] <= '0;
            end
            corrected_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (in_valid && !in_stall && corr_on)
            begin
                c.pos_x   = pos_x;
                c.pos_y   = pos_y;
                c.two_pad = two_pad;
                c.pad0_x  = pad0_x;
                c.pad0_y  = pad0_y;
                c.pad1_x  = pad1_x;
                c.pad1_y  = pad1_y;
                c.amp0    = amp0;
                c.amp1    = amp1;
                corrected_q = {corrected_q, correct_cluster(c)};
            end
            if (out_valid && !out_stall)
            begin
                if (corrected_q.size() == 0)
                begin
                    $error("unexpected transaction on output: new_x %0d new_y %0d",
                           new_x, new_y);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = corrected_q.pop_front();
                    if (e.new_x !== new_x || e.new_y !== new_y
                        || e.shift !== applied_shift || e.status !== status)
                    begin
                        fail_count <= fail_count + 1;
                    end
                    if (e.new_x !== new_x)
                    begin
                        $error("new_x expected %0d actual %0d", e.new_x, new_x);
                    end
                    if (e.new_y !== new_y)
                    begin
                        $error("new_y expected %0d actual %0d", e.new_y, new_y);
                    end
                    if (e.shift !== applied_shift)
                    begin
                        $error("applied_shift expected %0d actual %0d", e.shift, applied_shift);
                    end
                    if (e.status !== status)
                    begin
                        $error("status expected %0d actual %0d", e.status, status);
                    end
                end
            end
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_ENABLE)
                begin
                    corr_on <= cfg_wr_data[0];
                end
                else if (cfg_index >= CFG_COEF_0 && cfg_index < CFG_COEF_0 + N_COEF)
                begin
                    coef_q[cfg_index - CFG_COEF_0] <= cfg_wr_data;
                end
            end
            pending <= corrected_q.size();
        end
    end

endmodule

### sim/two_pad_eta_position_correction_top_tb.sv
// testbench top for the two-pad eta position correction block: clock, reset, config,
// directed and random cluster stimulus, verdict; uses tpepc_pkg and the checker module
module two_pad_eta_position_correction_top_tb;
    import tpepc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(7);
    localparam int DRAIN_CYCLES = 90;
    localparam int CYCLE_LIMIT  = 400000;
    localparam data_t DMAX = 32'sh7fffffff;
    localparam data_t DMIN = 32'sh80000000;

    logic clk;
    logic rst_n;
    logic in_valid, in_stall;
    data_t pos_x, pos_y, pad0_x, pad0_y, pad1_x, pad1_y;
    logic two_pad;
    logic [AMP_W-1:0] amp0, amp1;
    logic out_valid, out_stall;
    data_t new_x, new_y, applied_shift;
    logic [1:0] status;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0] cfg_wr_data;
    int fail_count, pending;
    int send_idle_pct, recv_stall_pct;
    int cycle_count;

    two_pad_eta_position_correction_top u_top (.*);

    two_pad_eta_position_correction_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        out_stall   <= ($urandom_range(0, 99) < recv_stall_pct);
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic item_t cluster(data_t px, data_t py, logic tp, data_t p0x, data_t p0y,
                                      data_t p1x, data_t p1y, int a0, int a1);
        item_t c;
        c.pos_x = px;  c.pos_y = py;  c.two_pad = tp;
        c.pad0_x = p0x; c.pad0_y = p0y; c.pad1_x = p1x; c.pad1_y = p1y;
        c.amp0 = a0[AMP_W-1:0]; c.amp1 = a1[AMP_W-1:0];
        return c;
    endfunction

    function automatic item_t random_cluster();
        item_t c;
        int    kind;
        kind = $urandom_range(0, 99);
        c.pos_x   = $urandom;
        c.pos_y   = $urandom;
        c.two_pad = (kind < 92) ? 1'b1 : 1'b0;
        c.pad0_x  = $urandom;
        c.pad0_y  = $urandom;
        c.pad1_x  = $urandom;
        c.pad1_y  = $urandom;
        c.amp0    = AMP_W'($urandom);
        c.amp1    = AMP_W'($urandom);
        if (kind < 65)
        begin
            c.pad1_x = c.pad0_x + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
            c.pad1_y = c.pad0_y + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        end
        else if (kind < 70)
        begin
            c.pad1_x = c.pad0_x;
            c.pad1_y = c.pad0_y;
        end
        else if (kind < 74)
        begin
            c.amp0 = '0;
            c.amp1 = '0;
        end
        else if (kind < 78)
        begin
            c.amp0 = '0;
        end
        else if (kind < 80)
        begin
            c.pad1_x = c.pad0_x;
        end
        if (kind % 17 == 0)
        begin
            c.pos_x = (kind & 1) ? DMAX : DMIN;
            c.pos_y = (kind & 2) ? DMAX : DMIN;
        end
        return c;
    endfunction

    task automatic send_cluster(input item_t c);
        logic stalled;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x <= c.pos_x;   pos_y <= c.pos_y;   two_pad <= c.two_pad;
        pad0_x <= c.pad0_x; pad0_y <= c.pad0_y; pad1_x <= c.pad1_x; pad1_y <= c.pad1_y;
        amp0 <= c.amp0;     amp1 <= c.amp1;
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        while (stalled);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_config(input logic enable, input data_t coefs [N_COEF]);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_ENABLE;
        cfg_wr_data <= {31'b0, enable};
        @(posedge clk);
        for (int k = 0; k < N_COEF; k++)
        begin
            cfg_index   <= CFG_IDX_W'(CFG_COEF_0 + k);
            cfg_wr_data <= coefs[k];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        data_t coefs [N_COEF];
        int    n_items;
        rst_n = 1'b0;
        in_valid = 1'b0; cfg_wr_en = 1'b0;
        cfg_index = '0; cfg_wr_data = '0;
        pos_x = '0; pos_y = '0; two_pad = 1'b0; pad0_x = '0; pad0_y = '0;
        pad1_x = '0; pad1_y = '0; amp0 = '0; amp1 = '0;
        send_idle_pct = 0; recv_stall_pct = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // disabled after reset: transactions dropped
        send_cluster(random_cluster());
        send_cluster(random_cluster());
        drain();

        coefs = '{32'sh00008000, 32'sh00010000, -32'sh00020000, 32'sh00003000,
                  -32'sh00001000, 32'sh00000800};
        load_config(1'b1, coefs);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_SPARE;
        cfg_wr_data <= 32'hffffffff;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);

        send_cluster(cluster(32'sh00010000, 32'sh00020000, 1'b0, 0, 0, 32'sh10000, 0, 5, 7));
        send_cluster(cluster(32'sh00010000, 32'sh00020000, 1'b1, 0, 0, 32'sh10000, 0, 0, 0));
        send_cluster(cluster(32'sh00010000, 32'sh00020000, 1'b1, 55, 66, 55, 66, 9, 3));
        send_cluster(cluster(0, 0, 1'b1, 0, 32'sh10000, 0, 0, 100, 300));
        send_cluster(cluster(0, 0, 1'b1, 0, 0, 0, 32'sh10000, 300, 100));
        send_cluster(cluster(0, 0, 1'b1, 0, 0, 32'sh10000, 32'sh8000, 1, 2));
        send_cluster(cluster(0, 0, 1'b1, 32'sh10000, 0, 0, 0, 1, 2));
        send_cluster(cluster(DMAX, DMAX, 1'b1, DMAX, DMAX, DMIN, DMIN, 65535, 65535));
        send_cluster(cluster(DMIN, DMIN, 1'b1, DMIN, DMAX, DMAX, DMIN, 65535, 0));
        send_cluster(cluster(DMAX, DMIN, 1'b1, DMIN, 0, DMAX, 0, 0, 65535));
        send_cluster(cluster(-1, -1, 1'b1, -1, -1, 0, 0, 65535, 1));
        send_cluster(cluster(DMAX, DMAX, 1'b0, DMAX, DMAX, DMAX, DMAX, 65535, 65535));
        drain();

        coefs = '{DMAX, DMAX, DMAX, DMAX, DMAX, DMAX};
        load_config(1'b1, coefs);
        send_cluster(cluster(DMAX, DMAX, 1'b1, DMAX, DMAX, 0, 0, 65535, 65535));
        send_cluster(cluster(DMIN, DMIN, 1'b1, 0, 0, DMAX, DMAX, 65535, 1));
        send_cluster(cluster(0, 0, 1'b1, 32'sh10000, DMIN, 0, 0, 3, 0));
        drain();

        for (int phase = 0; phase < 9; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            for (int k = 0; k < N_COEF; k++)
            begin
                case (phase)
                    1: coefs[k] = DMAX;
                    2: coefs[k] = DMIN;
                    3: coefs[k] = '0;
                    4: coefs[k] = $urandom;
                    default: coefs[k] = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
                endcase
            end
            load_config(phase != 6, coefs);
            n_items = (phase == 6) ? 60 : 205;
            for (int i = 0; i < n_items; i++)
            begin
                send_cluster(random_cluster());
                if (phase == 5 && i == 100)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    wait (pending == 0);
                end
            end
            drain();
        end

        if (fail_count == 0 && pending == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### files.f
+incdir+src
src/tpepc_pkg.sv
src/tpepc_norm.sv
src/tpepc_poly.sv
src/two_pad_eta_position_correction_top.sv
sim/two_pad_eta_position_correction_checker.sv
sim/two_pad_eta_position_correction_top_tb.sv
